[sv/restoring_divider_unit_defines.svh]
// ----------------------------------------------------------------------------
// Restoring divider unit assertion macros
// Concurrent assertion wrappers, clocked on clk_i, that can be compiled out.
// ----------------------------------------------------------------------------
`ifndef RESTORING_DIVIDER_UNIT_DEFINES_SVH
`define RESTORING_DIVIDER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property outside reset
`define RDIV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property at every edge, reset included
`define RDIV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define RDIV_ASSERT(lbl, prop, msg)
`define RDIV_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[sv/rdiv_pkg.sv]
// ----------------------------------------------------------------------------
// Restoring divider package
// Types shared by the divider stages and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rdiv_pkg;

  // Per-beat control that travels down the stage chain with the data
  typedef struct packed {
    logic valid;
    logic dbz;
  } rdiv_ctl_t;

endpackage

`default_nettype wire

[sv/rdiv_in_if.sv]
// ----------------------------------------------------------------------------
// Restoring divider request channel
// Valid/ready channel carrying the dividend and divisor of one division.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdiv_in_if #(
  parameter int WIDTH = 8
) ();

  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] dividend;
  logic [WIDTH-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);

endinterface

`default_nettype wire

[sv/rdiv_out_if.sv]
// ----------------------------------------------------------------------------
// Restoring divider result channel
// Valid/ready channel carrying quotient, remainder and the zero-divisor flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdiv_out_if #(
  parameter int WIDTH = 8
) ();

  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] quotient;
  logic [WIDTH-1:0] remainder;
  logic             div_by_zero;

  modport source (output valid, output quotient, output remainder, output div_by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input remainder, input div_by_zero,
                  output ready);

endinterface

`default_nettype wire

[sv/rdiv_stage.sv]
// ----------------------------------------------------------------------------
// Restoring divider stage
// One round of restoring division: shift the remainder/quotient pair left,
// trial-subtract the divisor, keep or restore, and register the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rdiv_stage #(
  parameter int WIDTH = 8
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire rdiv_pkg::rdiv_ctl_t ctl_i,
  output logic                  ready_o,
  input  wire  [WIDTH-1:0]      rem_i,
  input  wire  [WIDTH-1:0]      quo_i,
  input  wire  [WIDTH-1:0]      dsr_i,
  output rdiv_pkg::rdiv_ctl_t   ctl_o,
  input  wire                   ready_i,
  output logic [WIDTH-1:0]      rem_o,
  output logic [WIDTH-1:0]      quo_o,
  output logic [WIDTH-1:0]      dsr_o
);

  logic                valid_q;
  logic                dbz_q;
  logic [WIDTH-1:0]    rem_q, rem_d;
  logic [WIDTH-1:0]    quo_q, quo_d;
  logic [WIDTH-1:0]    dsr_q;
  logic [WIDTH:0]      rem_sh;
  logic [WIDTH+1:0]    diff;
  logic                fits;

  // Take a beat when empty or when the held beat moves on
  assign ready_o = !valid_q || ready_i;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    rem_sh = {rem_i, quo_i[WIDTH-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr_i};
    fits   = !diff[WIDTH+1];
    rem_d  = fits ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
    quo_d  = {quo_i[WIDTH-2:0], fits};
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= ctl_i.valid;
    end
  end

  // Load the payload with each new beat
  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      dsr_q <= dsr_i;
      dbz_q <= ctl_i.dbz;
    end
  end

  assign ctl_o.valid = valid_q;
  assign ctl_o.dbz   = dbz_q;
  assign rem_o       = rem_q;
  assign quo_o       = quo_q;
  assign dsr_o       = dsr_q;

endmodule

`default_nettype wire

[sv/restoring_divider_unit.sv]
// ----------------------------------------------------------------------------
// Restoring divider unit
// Pipelined unsigned restoring divider: WIDTH-bit quotient and remainder,
// one stage per quotient bit.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                                 Handshake
//   req_i    in   dividend, divisor (WIDTH each)          valid/ready
//   rsp_o    out  quotient, remainder (WIDTH), div_by_zero valid/ready
//
// A request beat passes through the WIDTH-stage chain to the result channel,
// each stage holding one compare-subtract of the partial remainder; one
// division enters per cycle while the result channel is ready.
// Reset clears only the stage valid bits.
// Under a stall each stage holds its beat; empty stages keep filling, so
// bubbles close up and the input stays open until the whole chain is full.
// A zero divisor runs through the same rounds and yields all-ones quotient
// and the dividend as remainder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "restoring_divider_unit_defines.svh"

module restoring_divider_unit #(
  parameter int WIDTH = 8
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  rdiv_in_if.sink  req_i,
  rdiv_out_if.source rsp_o
);

  rdiv_pkg::rdiv_ctl_t ctl_s   [WIDTH+1];
  logic                ready_s [WIDTH+1];
  logic [WIDTH-1:0]    rem_s   [WIDTH+1];
  logic [WIDTH-1:0]    quo_s   [WIDTH+1];
  logic [WIDTH-1:0]    dsr_s   [WIDTH+1];

  // Feed the request beat into the first round
  assign ctl_s[0].valid = req_i.valid;
  assign ctl_s[0].dbz   = (req_i.divisor == '0);
  assign rem_s[0]       = '0;
  assign quo_s[0]       = req_i.dividend;
  assign dsr_s[0]       = req_i.divisor;
  assign req_i.ready    = ready_s[0];

  // One registered stage per quotient bit
  for (genvar k = 0; k < WIDTH; k++) begin : g_round
    rdiv_stage #(
      .WIDTH (WIDTH)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_s[k]),
      .ready_o (ready_s[k]),
      .rem_i   (rem_s[k]),
      .quo_i   (quo_s[k]),
      .dsr_i   (dsr_s[k]),
      .ctl_o   (ctl_s[k+1]),
      .ready_i (ready_s[k+1]),
      .rem_o   (rem_s[k+1]),
      .quo_o   (quo_s[k+1]),
      .dsr_o   (dsr_s[k+1])
    );
  end

  // Last stage register drives the result channel
  assign ready_s[WIDTH]    = rsp_o.ready;
  assign rsp_o.valid       = ctl_s[WIDTH].valid;
  assign rsp_o.quotient    = quo_s[WIDTH];
  assign rsp_o.remainder   = rem_s[WIDTH];
  assign rsp_o.div_by_zero = ctl_s[WIDTH].dbz;

  // Assertions
  `RDIV_ASSERT_RST(a_rst_no_valid, !rst_ni |-> !rsp_o.valid, "result valid during reset")
  `RDIV_ASSERT(a_dbz_flag, rsp_o.valid |-> (rsp_o.div_by_zero == (dsr_s[WIDTH] == '0)), "zero-divisor flag mismatch")
  `RDIV_ASSERT(a_dbz_ones, (rsp_o.valid && rsp_o.div_by_zero) |-> (rsp_o.quotient == '1), "zero divisor without all-ones quotient")
  `RDIV_ASSERT(a_rem_small, (rsp_o.valid && !rsp_o.div_by_zero) |-> (rsp_o.remainder < dsr_s[WIDTH]), "remainder not below divisor")

endmodule

`default_nettype wire

[verif/tb_restoring_divider_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Restoring divider unit testbench
// Drives dividend/divisor beats into the pipelined divider and checks every
// quotient, remainder and zero-divisor flag against a local division model,
// in order, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb_restoring_divider_unit;

  localparam int WIDTH       = 8;
  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 4;
  // Watchdog bound on the whole run, far above what the slowest legal run needs
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1880;
  localparam int TAIL_ITEMS   = 300;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_AT     = 1200;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;
  } div_request_t;

  typedef struct packed {
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
    logic             div_by_zero;
  } div_result_t;

  logic clk_i;
  logic rst_ni;

  rdiv_in_if  #(.WIDTH(WIDTH)) req_if ();
  rdiv_out_if #(.WIDTH(WIDTH)) rsp_if ();

  restoring_divider_unit #(.WIDTH(WIDTH)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  div_request_t pending_requests[$];
  div_result_t  expected_results[$];
  int           total_items;
  int           items_sent;
  int           fail_count;
  int           report_count;
  int           sender_idle_left;
  int           receiver_stall_left;
  int           receiver_hold_left;
  bit           hold_started;
  bit           drain_done;
  int           cycle_count;

  // Unsigned restoring division with a WIDTH+1 bit partial remainder
  function automatic div_result_t predict_division(input logic [WIDTH-1:0] num,
                                                   input logic [WIDTH-1:0] den);
    div_result_t    res;
    logic [WIDTH:0] part;
    logic [WIDTH-1:0] quo;
    if (den == '0) begin
      res.quotient    = '1;
      res.remainder   = num;
      res.div_by_zero = 1'b1;
      return res;
    end
    part = '0;
    quo  = num;
    for (int k = 0; k < WIDTH; k++) begin
      part = {part[WIDTH-1:0], quo[WIDTH-1]};
      quo  = quo << 1;
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[0] = 1'b1;
      end
    end
    res.quotient    = quo;
    res.remainder   = part[WIDTH-1:0];
    res.div_by_zero = 1'b0;
    return res;
  endfunction

  // Mix of uniform operands, zero divisors, large and small divisors, and dividends below the divisor
  function automatic div_request_t random_request();
    div_request_t rq;
    int           pick;
    pick        = $urandom_range(0, 19);
    rq.dividend = WIDTH'($urandom_range(0, (1 << WIDTH) - 1));
    rq.divisor  = WIDTH'($urandom_range(0, (1 << WIDTH) - 1));
    if (pick == 0) begin
      rq.divisor = '0;
    end else if (pick <= 4) begin
      rq.divisor = WIDTH'($urandom_range(1 << (WIDTH - 1), (1 << WIDTH) - 1));
    end else if (pick <= 7) begin
      rq.divisor = WIDTH'($urandom_range(1, 15));
    end else if (pick == 8 && rq.divisor != '0) begin
      rq.dividend = WIDTH'($urandom_range(0, rq.divisor - 1));
    end
    return rq;
  endfunction

  function automatic bit roll_idle(input int phase);
    case (phase % 3)
      0:       return 1'b0;
      1:       return ($urandom_range(0, 7) == 0);
      default: return ($urandom_range(0, 2) == 0);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input div_result_t want,
                                 input div_result_t got);
    fail_count++;
    if (report_count < MAX_REPORTS) begin
      report_count++;
      $display("[%0t] %s: expected q=%0d r=%0d dbz=%0b, got q=%0d r=%0d dbz=%0b",
               $realtime, what, want.quotient, want.remainder, want.div_by_zero,
               got.quotient, got.remainder, got.div_by_zero);
    end
  endtask

  // Clock
  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // Sender: offer queued beats, hold a beat until taken, idle in bursts, pause once for a drain
  always @(posedge clk_i or negedge rst_ni) begin
    div_request_t rq;
    bit           offer;
    bit           in_tail;
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.dividend <= '0;
      req_if.divisor  <= '0;
      items_sent      <= 0;
      drain_done      <= 1'b0;
      sender_idle_left = 0;
    end else if (!(req_if.valid && !req_if.ready)) begin
      if (req_if.valid) begin
        expected_results.push_back(predict_division(req_if.dividend, req_if.divisor));
        items_sent <= items_sent + 1;
      end
      in_tail = (items_sent >= total_items - TAIL_ITEMS);
      offer   = 1'b0;
      if (sender_idle_left > 0) begin
        sender_idle_left--;
      end else if (!drain_done && items_sent >= DRAIN_AT) begin
        // Pause until the pipeline has emptied, then resume
        if (expected_results.size() == 0) drain_done <= 1'b1;
      end else if (pending_requests.size() == 0) begin
        offer = 1'b0;
      end else if (!in_tail && roll_idle(items_sent / 100)) begin
        sender_idle_left = $urandom_range(1, 11) - 1;
      end else begin
        rq              = pending_requests.pop_front();
        offer           = 1'b1;
        req_if.dividend <= rq.dividend;
        req_if.divisor  <= rq.divisor;
      end
      req_if.valid <= offer;
    end
  end

  // Long receiver hold-off, once, while the sender keeps offering
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiver_hold_left <= 0;
      hold_started       <= 1'b0;
    end else if (!hold_started && items_sent >= HOLD_AT) begin
      receiver_hold_left <= HOLD_CYCLES;
      hold_started       <= 1'b1;
    end else if (receiver_hold_left > 0) begin
      receiver_hold_left <= receiver_hold_left - 1;
    end
  end

  // Receiver: check each result beat against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    div_result_t got;
    div_result_t want;
    bit          take;
    if (!rst_ni) begin
      rsp_if.ready       <= 1'b0;
      receiver_stall_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.quotient    = rsp_if.quotient;
        got.remainder   = rsp_if.remainder;
        got.div_by_zero = rsp_if.div_by_zero;
        if (expected_results.size() == 0) begin
          want = '0;
          report_mismatch("unexpected result", want, got);
        end else begin
          want = expected_results.pop_front();
          if (got.quotient !== want.quotient || got.remainder !== want.remainder ||
              got.div_by_zero !== want.div_by_zero)
            report_mismatch("result mismatch", want, got);
        end
      end
      take = 1'b1;
      if (receiver_hold_left > 0) begin
        take = 1'b0;
      end else if (receiver_stall_left > 0) begin
        receiver_stall_left--;
        take = 1'b0;
      end else if (items_sent < total_items - TAIL_ITEMS &&
                   roll_idle(items_sent / 100 + 1)) begin
        receiver_stall_left = $urandom_range(1, 11) - 1;
        take = 1'b0;
      end
      rsp_if.ready <= take;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_restoring_divider_unit NOT OK");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    div_request_t rq;
    logic [WIDTH-1:0] edge_cases [$][2];
    fail_count   = 0;
    report_count = 0;
    cycle_count  = 0;
    rst_ni       = 1'b0;

    // Directed: extremes, zero divisor, divisor one, small divisors, divisors at and above half range
    edge_cases = '{'{8'd0, 8'd0}, '{8'd255, 8'd0}, '{8'd0, 8'd1}, '{8'd255, 8'd1},
                   '{8'd255, 8'd255}, '{8'd254, 8'd255}, '{8'd128, 8'd129},
                   '{8'd200, 8'd128}, '{8'd1, 8'd255}, '{8'd255, 8'd128},
                   '{8'd127, 8'd128}, '{8'd170, 8'd85}, '{8'd85, 8'd170},
                   '{8'd7, 8'd3}, '{8'd100, 8'd7}, '{8'd0, 8'd255}, '{8'd128, 8'd1},
                   '{8'd129, 8'd128}, '{8'd255, 8'd2}, '{8'd1, 8'd1},
                   '{8'd200, 8'd200}, '{8'd85, 8'd0}};
    foreach (edge_cases[i]) begin
      rq.dividend = edge_cases[i][0];
      rq.divisor  = edge_cases[i][1];
      pending_requests.push_back(rq);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_requests.push_back(random_request());
    total_items = pending_requests.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every beat to be taken, then for every result
    @(posedge clk_i);
    while (pending_requests.size() != 0 || req_if.valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4 * WIDTH) @(posedge clk_i);

    fail_count += expected_results.size();
    if (fail_count == 0) begin
      $display("tb_restoring_divider_unit OK");
    end else begin
      $display("tb_restoring_divider_unit NOT OK");
    end
    $finish;
  end

endmodule
